// ===== rtl/core/ed_pkg.sv =====
// Shared types and constants for the edit distance engine.
package ed_pkg;

	localparam int SYM_PORT_W  = 8;
	localparam int DIST_W      = 9;
	localparam int DIST_MAX    = 511;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_INIT    = 7'b0000010,
		ST_ROW_RD  = 7'b0000100,
		ST_ROW     = 7'b0001000,
		ST_CELL_RD = 7'b0010000,
		ST_CELL    = 7'b0100000,
		ST_DONE    = 7'b1000000
	} ed_state_t;

	function automatic logic [DIST_W-1:0] ed_saturate(input logic [31:0] value);
		ed_saturate = (value > 32'(DIST_MAX)) ? DIST_W'(DIST_MAX) : value[DIST_W-1:0];
	endfunction

endpackage

// ===== rtl/core/ed_min3.sv =====
// Shared cell unit: minimum of delete, insert and substitute costs.
module ed_min3
	import ed_pkg::*;
#(
	parameter int W = 9
) (
	input  logic [W-1:0] above,
	input  logic [W-1:0] left,
	input  logic [W-1:0] diag,
	input  logic         mismatch,
	output logic [W-1:0] cost
);

	logic [W:0] del_c;
	logic [W:0] ins_c;
	logic [W:0] sub_c;
	logic [W:0] t_c;
	logic [W:0] m_c;

	always_comb begin
		del_c = {1'b0, above} + (W+1)'(1);
		ins_c = {1'b0, left} + (W+1)'(1);
		sub_c = {1'b0, diag} + (W+1)'(mismatch);
		t_c   = (del_c < ins_c) ? del_c : ins_c;
		m_c   = (t_c < sub_c) ? t_c : sub_c;
		cost  = m_c[W-1:0];
	end

endmodule

// ===== rtl/core/edit_distance_engine.sv =====
// Levenshtein edit distance engine with a DP over a cost row memory and a shared cell unit.
//
//  channel | dir | tdata             | tuser                          | tlast
//  s_*     | in  | [7:0] symbol      | [0] which_string, [1] empty_req| last
//  m_*     | out | [8:0] distance    | [0] too_long                   | -
//
//  First-string items and non-final second-string items are taken while idle.
//  A final second-string item starts the DP pass for lengths m and n, paced by
//  the single read and write port of the cost row memory.
//  An overflowed pair, or a pair with an empty string, skips the DP pass.
//  s_tready is low while a distance is computed; a held result stalls only
//  the hand-over to the output register. No clearing pass follows reset.
module edit_distance_engine
	import ed_pkg::*;
#(
	parameter int MAX_LEN     = 256,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SYM_PORT_W-1:0]  s_tdata,  // [7:0] symbol
	input  logic [1:0]             s_tuser,  // [0] which_string, [1] empty_req
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [8:0] distance
	output logic [0:0]             m_tuser   // [0] too_long
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int SYM_W = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;

	ed_state_t         state_q;
	logic [CNT_W-1:0]  first_count_q;
	logic [CNT_W-1:0]  second_count_q;
	logic              overflow_q;
	logic              first_done_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  diag_q;
	logic [CNT_W-1:0]  left_q;
	logic [SYM_W-1:0]  a_q;
	logic [CNT_W-1:0]  res_q;
	logic              res_ovf_q;
	logic              m_tvalid_q;
	logic [DIST_W-1:0] dist_q;
	logic              too_long_q;

	logic [SYM_W-1:0]  first_store [MAX_LEN];
	logic [SYM_W-1:0]  second_store [MAX_LEN];
	logic [CNT_W-1:0]  cost_row [MAX_LEN+1];
	logic [SYM_W-1:0]  fs_rdata_q;
	logic [SYM_W-1:0]  ss_rdata_q;
	logic [CNT_W-1:0]  cr_rdata_q;

	logic              accept;
	logic              second;
	logic              empty;
	logic [SYM_W-1:0]  sym;
	logic [CNT_W-1:0]  fidx;
	logic              f_push;
	logic              f_full;
	logic              s_push;
	logic              s_full;
	logic              fin;
	logic              ovf_next;
	logic [CNT_W-1:0]  f_count_next;
	logic [CNT_W-1:0]  s_count_next;
	logic              cr_we;
	logic [CNT_W-1:0]  cr_waddr;
	logic [CNT_W-1:0]  cr_wdata;
	logic [CNT_W-1:0]  cr_raddr;
	logic [CNT_W-1:0]  cell_cost;
	logic              out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign second   = s_tuser[0];
	assign empty    = s_tuser[1];
	assign sym      = s_tdata[SYM_W-1:0];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W-DIST_W)'(0), dist_q};
	assign m_tuser  = too_long_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		fidx         = first_done_q ? '0 : first_count_q;
		f_full       = (fidx == CNT_W'(MAX_LEN));
		f_push       = !second && !empty && !f_full;
		s_full       = (second_count_q == CNT_W'(MAX_LEN));
		s_push       = second && !empty && !s_full;
		fin          = second && (empty || s_tlast);
		ovf_next     = overflow_q || (!second && !empty && f_full) ||
		               (second && !empty && s_full);
		f_count_next = empty ? '0 : (f_push ? fidx + CNT_W'(1) : fidx);
		s_count_next = empty ? '0 : (s_push ? second_count_q + CNT_W'(1) : second_count_q);
	end

	ed_min3 #(
		.W(CNT_W)
	) u_min3 (
		.above    (cr_rdata_q),
		.left     (left_q),
		.diag     (diag_q),
		.mismatch (a_q != ss_rdata_q),
		.cost     (cell_cost)
	);

	always_comb begin
		cr_we    = 1'b0;
		cr_waddr = j_q;
		cr_wdata = j_q;
		cr_raddr = j_q;
		case (state_q)
			ST_INIT: begin
				cr_we = 1'b1;
			end
			ST_ROW_RD: begin
				cr_raddr = '0;
			end
			ST_ROW: begin
				cr_we    = 1'b1;
				cr_waddr = '0;
				cr_wdata = i_q;
			end
			ST_CELL: begin
				cr_we    = 1'b1;
				cr_wdata = cell_cost;
			end
			default: begin
				cr_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && f_push) begin
			first_store[IDX_W'(fidx)] <= sym;
		end
		if (accept && s_push) begin
			second_store[IDX_W'(second_count_q)] <= sym;
		end
		if (cr_we) begin
			cost_row[cr_waddr] <= cr_wdata;
		end
		fs_rdata_q <= first_store[IDX_W'(i_q - CNT_W'(1))];
		ss_rdata_q <= second_store[IDX_W'(j_q - CNT_W'(1))];
		cr_rdata_q <= cost_row[cr_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			first_count_q  <= '0;
			second_count_q <= '0;
			overflow_q     <= 1'b0;
			first_done_q   <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						overflow_q <= ovf_next;
						if (!second) begin
							first_count_q <= f_count_next;
							first_done_q  <= empty || s_tlast;
						end else begin
							second_count_q <= s_count_next;
							if (fin) begin
								j_q     <= '0;
								i_q     <= CNT_W'(1);
								state_q <= ST_INIT;
								if (ovf_next || first_count_q == '0 || s_count_next == '0) begin
									state_q <= ST_DONE;
								end
							end
						end
					end
				end
				ST_INIT: begin
					if (j_q == second_count_q) begin
						state_q <= ST_ROW_RD;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_ROW_RD: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					j_q     <= CNT_W'(1);
					state_q <= ST_CELL_RD;
				end
				ST_CELL_RD: begin
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					if (j_q == second_count_q) begin
						if (i_q == first_count_q) begin
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= ST_ROW_RD;
						end
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= ST_CELL_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q     <= 1'b1;
						first_count_q  <= '0;
						second_count_q <= '0;
						overflow_q     <= 1'b0;
						first_done_q   <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_ovf_q <= ovf_next;
				if (ovf_next) begin
					res_q <= CNT_W'(MAX_LEN);
				end else if (first_count_q == '0) begin
					res_q <= s_count_next;
				end else begin
					res_q <= first_count_q;
				end
			end
			ST_ROW: begin
				diag_q <= cr_rdata_q;
				a_q    <= fs_rdata_q;
				left_q <= i_q;
			end
			ST_CELL: begin
				diag_q <= cr_rdata_q;
				left_q <= cell_cost;
				res_q  <= cell_cost;
			end
			ST_DONE: begin
				if (out_free) begin
					dist_q     <= ed_saturate(32'(res_q));
					too_long_q <= res_ovf_q;
				end
			end
			default: begin
				res_ovf_q <= res_ovf_q;
			end
		endcase
	end

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		first_count_q <= CNT_W'(MAX_LEN) && second_count_q <= CNT_W'(MAX_LEN))
		else $error("stored length beyond maximum");

	a_cell_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |-> (j_q != '0 && j_q <= second_count_q &&
		i_q != '0 && i_q <= first_count_q))
		else $error("cell index outside the DP table");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not handed to the output register");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL || state_q == ST_INIT) |=> !accept)
		else $error("transaction taken during computation");

endmodule
